>>> hdl/cprun_pkg.sv
// Package for the contiguous page run allocator.
// Holds field codes, address constants and the control/status structs
// shared by the controller, the datapath and the top level.
package cprun_pkg;

  localparam int MAX_RUN = 64;

  localparam logic [63:0] PAGE_MASK   = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] PAGE_SIZE   = 64'h0000_0000_0000_1000;
  localparam logic [63:0] PRESENT_BIT = 64'h0000_0000_0000_0001;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'b0;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD     = 2'd1;
  localparam status_t ST_NOSPACE = 2'd2;
  localparam status_t ST_OUTSIDE = 2'd3;

  typedef struct packed {
    logic    clr_wr;
    logic    capture;
    logic    srch_init;
    logic    srch_eval;
    logic    unmap_start;
    logic    mark_rd;
    logic    mark_wr;
    logic    emit_load;
    logic    stat_load;
    status_t stat_code;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic arg_bad;
    logic outside;
    logic is_unmap;
    logic hit;
    logic last_word;
    logic mark_more;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/cprun_ctrl.sv
// Controller state machine of the page run allocator.
// Sequences clearing, argument checks, the word scan, map updates and
// result emission; uses cprun_pkg.
module cprun_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_ready,
  input  cprun_pkg::sts_t sts,
  output cprun_pkg::cmd_t cmd
);
  import cprun_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SEV   = 4'd4;
  localparam logic [3:0] S_MRD   = 4'd5;
  localparam logic [3:0] S_MWR   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_STAT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  status_t    stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      stat_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stat_nxt      = stat_r;
    cmd           = '0;
    cmd.stat_code = stat_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.arg_bad) begin
          stat_nxt  = ST_BAD;
          state_nxt = S_STAT;
        end else if (sts.is_unmap) begin
          if (sts.outside) begin
            stat_nxt  = ST_OUTSIDE;
            state_nxt = S_STAT;
          end else begin
            cmd.unmap_start = 1'b1;
            state_nxt       = S_MRD;
          end
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        cmd.srch_eval = 1'b1;
        if (sts.hit) begin
          state_nxt = S_MRD;
        end else if (sts.last_word) begin
          stat_nxt  = ST_NOSPACE;
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_MRD: begin
        cmd.mark_rd = 1'b1;
        state_nxt   = S_MWR;
      end
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = sts.mark_more ? S_MRD : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.stat_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

>>> hdl/cprun_dp.sv
// Datapath of the page run allocator: used-page memory, window search,
// run marking, address generation and the output register.
// Driven by cprun_ctrl through cprun_pkg command and status structs.
module cprun_dp #(
  parameter int REGION_PAGES = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cprun_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                        cfg_wdata,
  input  logic                               in_action,
  input  logic [63:0]                        in_phys,
  input  logic [63:0]                        in_virt,
  input  logic [6:0]                         in_count,
  input  logic [63:0]                        in_flags,
  input  cprun_pkg::cmd_t                    cmd,
  output cprun_pkg::sts_t                    sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_command,
  output logic [63:0]                        out_virt,
  output logic [63:0]                        out_phys,
  output logic [63:0]                        out_flags,
  output cprun_pkg::status_t                 out_status,
  output logic                               out_last
);
  import cprun_pkg::*;

  localparam int WORDS = (REGION_PAGES + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = WAW + 6;
  localparam int PW1   = PW + 1;
  localparam int TAIL  = REGION_PAGES % 64;
  localparam logic [63:0] TAIL_MASK = (TAIL == 0) ? {64{1'b1}} : ((64'd1 << TAIL) - 64'd1);

  logic [63:0] mem [WORDS];
  logic [63:0] rd_r;

  logic [63:0] base_r;
  logic        action_r;
  logic [63:0] phys_r, virt_r, flags_r;
  logic [6:0]  cnt_r;

  logic [WAW-1:0] waddr_r;
  logic [63:0]    prev_free_r;
  logic [PW-1:0]  start_r;
  logic           sel_r;
  logic [63:0]    va_r, pa_r;
  logic [6:0]     i_r;

  logic           out_valid_r;
  logic           out_command_r;
  logic [63:0]    out_virt_r, out_phys_r, out_flags_r;
  status_t        out_status_r;
  logic           out_last_r;

  logic           last_word;
  logic [63:0]    cur_free;
  logic [127:0]   f [7];
  logic [127:0]   g;
  logic [63:0]    hits;
  logic [5:0]     jpos;
  logic [PW1-1:0] start_sum;
  logic [63:0]    diff;
  logic [52:0]    reach;
  logic           outside;
  logic           arg_bad;
  logic [127:0]   run_mask;
  logic [63:0]    part;
  logic [WAW-1:0] mark_addr;
  logic [WAW-1:0] rd_addr;
  logic [WAW-1:0] wr_addr;
  logic [63:0]    wr_data;
  logic           wr_en;

  assign last_word = (waddr_r == WAW'(WORDS - 1));
  assign cur_free  = ~rd_r & (last_word ? TAIL_MASK : {64{1'b1}});

  always_comb begin
    f[0] = {cur_free, prev_free_r};
    for (int k = 1; k < 7; k++) begin
      f[k] = f[k-1] & (f[k-1] << (1 << (k - 1)));
    end
    g = {128{1'b1}};
    for (int k = 0; k < 7; k++) begin
      if (cnt_r[k]) g = g & (f[k] << (cnt_r & 7'((1 << k) - 1)));
    end
    hits = g[127:64];
    jpos = '0;
    for (int j = 63; j >= 0; j--) begin
      if (hits[j]) jpos = 6'(j);
    end
  end

  assign start_sum = {1'b0, waddr_r, jpos} + PW1'(1) - PW1'(cnt_r);

  assign diff    = virt_r - base_r;
  assign reach   = {1'b0, diff[63:12]} + 53'(cnt_r);
  assign outside = (virt_r < base_r) || (reach > 53'(REGION_PAGES));
  assign arg_bad = (cnt_r == 7'd0) || (cnt_r > 7'(MAX_RUN)) ||
                   (!action_r && (phys_r == 64'd0)) || (action_r && (virt_r == 64'd0));

  assign run_mask  = ((128'd1 << cnt_r) - 128'd1) << start_r[5:0];
  assign part      = sel_r ? run_mask[127:64] : run_mask[63:0];
  assign mark_addr = start_r[PW-1:6] + WAW'(sel_r);

  assign rd_addr = cmd.mark_rd ? mark_addr : waddr_r;
  assign wr_en   = cmd.clr_wr || cmd.mark_wr;
  assign wr_addr = cmd.clr_wr ? waddr_r : mark_addr;
  assign wr_data = cmd.clr_wr ? 64'd0 : (action_r ? (rd_r & ~part) : (rd_r | part));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 64'd0;
      waddr_r <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_REGION_BASE)) base_r <= cfg_wdata;
      if (cmd.srch_init) begin
        waddr_r <= '0;
      end else if (cmd.clr_wr || cmd.srch_eval) begin
        waddr_r <= waddr_r + WAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      phys_r   <= in_phys;
      virt_r   <= in_virt;
      cnt_r    <= in_count;
      flags_r  <= in_flags;
    end
    if (cmd.srch_init) begin
      prev_free_r <= 64'd0;
    end else if (cmd.srch_eval) begin
      prev_free_r <= cur_free;
    end
    if (cmd.unmap_start) begin
      start_r <= diff[PW+11:12];
      sel_r   <= 1'b0;
    end else if (cmd.srch_eval && (|hits)) begin
      start_r <= start_sum[PW-1:0];
      sel_r   <= 1'b0;
    end else if (cmd.mark_wr) begin
      sel_r <= 1'b1;
    end
    if (cmd.mark_rd && !sel_r) begin
      va_r <= action_r ? virt_r : (base_r + 64'({start_r, 12'b0}));
      pa_r <= phys_r & PAGE_MASK;
      i_r  <= 7'd0;
    end else if (cmd.emit_load) begin
      va_r <= va_r + PAGE_SIZE;
      pa_r <= pa_r + PAGE_SIZE;
      i_r  <= i_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.stat_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_command_r <= action_r;
      out_virt_r    <= va_r;
      out_phys_r    <= action_r ? 64'd0 : pa_r;
      out_flags_r   <= action_r ? 64'd0 : (flags_r | PRESENT_BIT);
      out_status_r  <= ST_OK;
      out_last_r    <= (i_r == cnt_r - 7'd1);
    end else if (cmd.stat_load) begin
      unique case (cmd.stat_code)
        ST_NOSPACE: out_command_r <= CMD_MAP;
        ST_OUTSIDE: out_command_r <= CMD_UNMAP;
        ST_BAD:     out_command_r <= action_r;
        ST_OK:      out_command_r <= action_r;
      endcase
      out_virt_r   <= 64'd0;
      out_phys_r   <= 64'd0;
      out_flags_r  <= 64'd0;
      out_status_r <= cmd.stat_code;
      out_last_r   <= 1'b1;
    end
  end

  assign sts.clr_done  = last_word;
  assign sts.arg_bad   = arg_bad;
  assign sts.outside   = outside;
  assign sts.is_unmap  = (action_r == CMD_UNMAP);
  assign sts.hit       = |hits;
  assign sts.last_word = last_word;
  assign sts.mark_more = !sel_r && (|run_mask[127:64]);
  assign sts.emit_last = (i_r == cnt_r - 7'd1);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_virt    = out_virt_r;
  assign out_phys    = out_phys_r;
  assign out_flags   = out_flags_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

endmodule

>>> hdl/contiguous_page_run_allocator_core.sv
// First-fit page run allocator: a map scans the used-page memory one 64-bit word at a time
// (memory read, then window evaluation) over up to ceil(REGION_PAGES/64) words, then marks
// one or two words, then emits one result per cycle unless out_tready holds it back.
// An unmap skips the scan; a rejected request gives its single status result.
// After reset a clearing pass writes ceil(REGION_PAGES/64) words, one a cycle, during which
// no request is taken; configuration writes are accepted throughout.
module contiguous_page_run_allocator_core #(
  parameter int REGION_PAGES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cprun_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // map_pa [63:0], virt_addr_in [127:64], page_count [134:128],
  // page_flags_in [198:135], zero [199]
  input  logic [199:0]                    in_tdata,
  // action [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // virt_addr [63:0], page_pa [127:64], page_flags [191:128], status [193:192],
  // zero [199:194]
  output logic [199:0]                    out_tdata,
  // command [0]
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import cprun_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        in_ready;
  logic [63:0] o_virt, o_phys, o_flags;
  status_t     o_status;

  cprun_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cprun_dp #(
    .REGION_PAGES (REGION_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_action   (in_tuser),
    .in_phys     (in_tdata[63:0]),
    .in_virt     (in_tdata[127:64]),
    .in_count    (in_tdata[134:128]),
    .in_flags    (in_tdata[198:135]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_command (out_tuser),
    .out_virt    (o_virt),
    .out_phys    (o_phys),
    .out_flags   (o_flags),
    .out_status  (o_status),
    .out_last    (out_tlast)
  );

  assign in_tready = in_ready;
  assign out_tdata = {6'd0, o_status, o_flags, o_phys, o_virt};

  a_clear_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.stat_load) |-> sts.out_free)
    else $error("output register overwritten while held");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stat_load |=> (out_tvalid && out_tlast && (out_tdata[193:192] != ST_OK)))
    else $error("status result not marked last");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.mark_wr))
    else $error("clear and mark write together");

endmodule
